[hw/rtl/cpm_pkg.sv]
// Shared constants, types and command/status structs of the CIDR prefix matcher.
`default_nettype none

package cpm_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;

   // Stream payload widths.
   localparam int REQ_TDATA_W = 136;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 8;

   localparam logic [7:0]  V4_MAX_PREFIX = 8'd32;
   localparam logic [7:0]  V6_MAX_PREFIX = 8'd128;
   localparam logic [31:0] MAPPED_TAG    = 32'h0000_ffff;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_PREFIX = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef struct packed {
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic        v4;
      logic [7:0]  plen;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // latch the accepted item and clear the result
      logic add;    // check and store the latched network
      logic scan;   // step the lookup scan
      logic emit;   // move the result into the output register
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

[hw/rtl/cidr_prefix_matcher.sv]
// Top level of the CIDR prefix matcher: stream ports, controller and datapath.
//
//   Channel  Direction  Carries
//   req_     in         add or lookup item: address, family, prefix length
//   rsp_     out        one result item per request: matched flag, status
//
// An add is checked and, if it passes, stored before its result goes to the output register;
// a lookup reads one entry per cycle from the entry memory, compares the last one read and
// sees the scan end before its result goes there. req_tready returns as the result enters
// the output register. Reset clears the entry count, scan index, compare flag, output valid
// flag and controller state, not the entry memory. A new request is taken while the previous
// result waits in the output register; the next result then waits until rsp_tready drains it.
`default_nettype none

module cidr_prefix_matcher #(
   parameter int TABLE_ENTRIES = cpm_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [63:0] address_high, [127:64] address_low, [135:128] prefix_length
   input  wire logic [cpm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] func, [1] is_ipv4
   input  wire logic [cpm_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [0] matched, [2:1] status, [7:3] zero
   output logic [cpm_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);
   import cpm_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic         rsp_matched;
   logic [1:0]   rsp_status;

   cpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser[0]),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   cpm_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .in_addr_hi  (req_tdata[63:0]),
      .in_addr_lo  (req_tdata[127:64]),
      .in_v4       (req_tuser[1]),
      .in_plen     (req_tdata[135:128]),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_matched (rsp_matched),
      .rsp_status  (rsp_status)
   );

   assign rsp_tdata = {5'd0, rsp_status, rsp_matched};

endmodule

`default_nettype wire

[hw/rtl/cpm_ctrl.sv]
// Controller state machine of the CIDR prefix matcher.
`default_nettype none

module cpm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_func,
   output logic                       req_tready,
   output cpm_pkg::ctrl_cmd_type      cmd,
   input  wire cpm_pkg::dp_stat_type  stat
);
   import cpm_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ADD  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = (req_func == FUNC_LOOKUP) ? S_SCAN : S_ADD;
            end
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_DONE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/cpm_dp.sv]
// Datapath of the CIDR prefix matcher: item registers, entry memory, scan and output register.
`default_nettype none

module cpm_dp #(
   parameter int TABLE_ENTRIES = cpm_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [63:0]           in_addr_hi,
   input  wire logic [63:0]           in_addr_lo,
   input  wire logic                  in_v4,
   input  wire logic [7:0]            in_plen,
   input  wire cpm_pkg::ctrl_cmd_type cmd,
   output cpm_pkg::dp_stat_type       stat,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic                       rsp_matched,
   output logic [1:0]                 rsp_status
);
   import cpm_pkg::*;

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

   // Normalized form of the incoming address.
   logic        mapped;
   logic        norm_v4;
   logic [63:0] norm_hi;
   logic [63:0] norm_lo;

   logic [63:0] key_hi_ff;
   logic [63:0] key_lo_ff;
   logic        key_v4_ff;
   logic [7:0]  key_plen_ff;

   entry_type   entry_mem_ff [TABLE_ENTRIES];
   entry_type   entry_q_ff;
   entry_type   wr_entry;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W-1:0] idx_in;
   logic             cmp_vld_ff;
   logic             cmp_vld_in;
   logic             rd_en;
   logic             wr_en;

   logic             too_long;
   logic             is_full;
   logic [127:0]     lead_mask;
   logic             hit;

   logic             res_matched_ff;
   logic             res_matched_in;
   logic [1:0]       res_status_ff;
   logic [1:0]       res_status_in;

   logic             rsp_tvalid_ff;
   logic             rsp_tvalid_in;
   logic             rsp_matched_ff;
   logic [1:0]       rsp_status_ff;

   // An IPv4-mapped IPv6 address becomes plain IPv4; IPv4 keeps only bits 127..96.
   always_comb begin
      mapped  = !in_v4 && (in_addr_hi == 64'd0) && (in_addr_lo[63:32] == MAPPED_TAG);
      norm_v4 = in_v4 || mapped;
      if (mapped) begin
         norm_hi = {in_addr_lo[31:0], 32'd0};
      end else if (in_v4) begin
         norm_hi = {in_addr_hi[63:32], 32'd0};
      end else begin
         norm_hi = in_addr_hi;
      end
      norm_lo = norm_v4 ? 64'd0 : in_addr_lo;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_hi_ff   <= norm_hi;
         key_lo_ff   <= norm_lo;
         key_v4_ff   <= norm_v4;
         key_plen_ff <= in_plen;
      end
   end

   // Add: the prefix check takes priority over the full check.
   assign too_long = key_plen_ff > (key_v4_ff ? V4_MAX_PREFIX : V6_MAX_PREFIX);
   assign is_full  = (count_ff == CNT_FULL);
   assign wr_en    = cmd.add && !too_long && !is_full;

   always_comb begin
      wr_entry.addr_hi = key_hi_ff;
      wr_entry.addr_lo = key_lo_ff;
      wr_entry.v4      = key_v4_ff;
      wr_entry.plen    = key_plen_ff;
   end

   always_comb begin
      count_in = count_ff;
      if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // Scan: one entry read per cycle, compared in the cycle after its read.
   assign rd_en = cmd.scan && (idx_ff != count_ff);

   always_comb begin
      idx_in     = idx_ff;
      cmp_vld_in = 1'b0;
      if (cmd.load) begin
         idx_in = '0;
      end else if (rd_en) begin
         idx_in     = idx_ff + CNT_W'(1);
         cmp_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[count_ff[IDX_W-1:0]] <= wr_entry;
      end
      if (rd_en) begin
         entry_q_ff <= entry_mem_ff[idx_ff[IDX_W-1:0]];
      end
   end

   always_comb begin
      for (int k = 0; k < 128; k++) begin
         lead_mask[127 - k] = (8'(k) < entry_q_ff.plen);
      end
   end

   assign hit = cmp_vld_ff && (entry_q_ff.v4 == key_v4_ff) &&
                ((({key_hi_ff, key_lo_ff} ^ {entry_q_ff.addr_hi, entry_q_ff.addr_lo})
                  & lead_mask) == 128'd0);

   always_comb begin
      res_matched_in = res_matched_ff;
      res_status_in  = res_status_ff;
      if (cmd.load) begin
         res_matched_in = 1'b0;
         res_status_in  = STATUS_OK;
      end else if (cmd.add) begin
         if (too_long) begin
            res_status_in = STATUS_PREFIX;
         end else if (is_full) begin
            res_status_in = STATUS_FULL;
         end
      end else if (hit) begin
         res_matched_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      res_matched_ff <= res_matched_in;
      res_status_ff  <= res_status_in;
      if (cmd.emit) begin
         rsp_matched_ff <= res_matched_ff;
         rsp_status_ff  <= res_status_ff;
      end
   end

   // Output register: a new result enters when the old one leaves or is gone.
   always_comb begin
      stat.scan_done = (idx_ff == count_ff) && !cmp_vld_ff;
      stat.out_free  = !rsp_tvalid_ff || rsp_tready;
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         idx_ff        <= '0;
         cmp_vld_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid  = rsp_tvalid_ff;
   assign rsp_matched = rsp_matched_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the CIDR prefix matcher: directed table, random items, scoreboard.
`timescale 1ns / 1ps

module testbench;
   import cpm_pkg::*;

   localparam int NET_SLOTS      = TABLE_ENTRIES_DEF;
   localparam int ITEMS_PER_PHASE = 385;
   localparam int STALL_LIMIT    = 4000;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct {
      logic        func;
      logic [63:0] hi;
      logic [63:0] lo;
      logic        v4;
      logic [7:0]  plen;
      logic        typed;
      logic        exp_matched;
      logic [1:0]  exp_status;
   } net_request_type;

   typedef struct packed {
      logic       matched;
      logic [1:0] status;
   } match_result_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [63:0] address_high, [127:64] address_low, [135:128] prefix_length
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // [0] func, [1] is_ipv4
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [0] matched, [2:1] status, [7:3] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Shadow copy of the network table, stored in normalized form.
   logic [63:0] net_hi [NET_SLOTS];
   logic [63:0] net_lo [NET_SLOTS];
   logic        net_v4 [NET_SLOTS];
   logic [7:0]  net_plen [NET_SLOTS];
   int          net_count = 0;

   match_result_type pending_results[$];
   net_request_type  directed_rows[$];

   int idle_pct  = 0;
   int stall_pct = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;
   int n_add_ok = 0, n_add_prefix = 0, n_add_full = 0;
   int n_hit = 0, n_miss = 0;

   cidr_prefix_matcher u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Turn the mapped IPv6 form into IPv4 and drop the bits an IPv4 address does not use.
   function automatic void normalize_addr(inout logic [63:0] hi, inout logic [63:0] lo,
                                          inout logic v4);
      if (!v4 && hi == 64'd0 && lo[63:32] == MAPPED_TAG) begin
         hi = {lo[31:0], 32'd0};
         lo = 64'd0;
         v4 = 1'b1;
      end else if (v4) begin
         hi[31:0] = 32'd0;
         lo = 64'd0;
      end
   endfunction

   function automatic logic [127:0] prefix_mask(input logic [7:0] plen);
      if (plen == 8'd0)
         return '0;
      return {128{1'b1}} << (128 - int'(plen));
   endfunction

   // Applies one accepted item to the shadow table and returns the result it must produce.
   function automatic match_result_type cidr_predict(input net_request_type it);
      logic [63:0]      hi;
      logic [63:0]      lo;
      logic             v4;
      logic [7:0]       limit;
      match_result_type r;
      hi = it.hi;
      lo = it.lo;
      v4 = it.v4;
      r.matched = 1'b0;
      r.status = STATUS_OK;
      normalize_addr(hi, lo, v4);
      if (it.func == FUNC_ADD) begin
         limit = v4 ? V4_MAX_PREFIX : V6_MAX_PREFIX;
         if (it.plen > limit) begin
            r.status = STATUS_PREFIX;
            n_add_prefix++;
         end else if (net_count >= NET_SLOTS) begin
            r.status = STATUS_FULL;
            n_add_full++;
         end else begin
            net_hi[net_count] = hi;
            net_lo[net_count] = lo;
            net_v4[net_count] = v4;
            net_plen[net_count] = it.plen;
            net_count++;
            n_add_ok++;
         end
      end else begin
         for (int i = 0; i < net_count; i++) begin
            if (net_v4[i] == v4 &&
                ((({hi, lo} ^ {net_hi[i], net_lo[i]}) & prefix_mask(net_plen[i])) == '0))
               r.matched = 1'b1;
         end
         if (r.matched)
            n_hit++;
         else
            n_miss++;
      end
      return r;
   endfunction

   function automatic void add_row(input logic func, input logic [63:0] hi,
                                   input logic [63:0] lo, input logic v4, input logic [7:0] plen,
                                   input logic typed, input logic exp_matched,
                                   input logic [1:0] exp_status);
      net_request_type row;
      row.func = func;
      row.hi = hi;
      row.lo = lo;
      row.v4 = v4;
      row.plen = plen;
      row.typed = typed;
      row.exp_matched = exp_matched;
      row.exp_status = exp_status;
      directed_rows = {directed_rows, row};
   endfunction

   // Random item: mostly lookups aimed at stored networks, some adds, some noise.
   function automatic net_request_type random_request(input bit last_phase);
      net_request_type it;
      logic [127:0]    a;
      logic [63:0]     hi;
      logic [63:0]     lo;
      logic            v4;
      int              sel;
      int              idx;
      int              width;
      int              j;
      int              p;
      sel = $urandom_range(99);
      it.typed = 1'b0;
      it.exp_matched = 1'b0;
      it.exp_status = STATUS_OK;
      it.plen = 8'($urandom_range(255));
      it.hi = {$urandom, $urandom};
      it.lo = {$urandom, $urandom};
      it.v4 = 1'($urandom_range(1));
      if (sel < 25) begin
         it.func = FUNC_ADD;
         if ($urandom_range(7) == 0) begin
            it.v4 = 1'b0;
            it.hi = 64'd0;
            it.lo = {MAPPED_TAG, $urandom};
         end
         hi = it.hi;
         lo = it.lo;
         v4 = it.v4;
         normalize_addr(hi, lo, v4);
         width = v4 ? int'(V4_MAX_PREFIX) : int'(V6_MAX_PREFIX);
         // Keep the last slot free until the final phase stores the catch-all network.
         if ((net_count >= NET_SLOTS - 1 && !last_phase) || $urandom_range(2) == 0)
            it.plen = 8'($urandom_range(255, width + 1));
         else
            it.plen = 8'($urandom_range(width, 1));
      end else if (sel < 90 && net_count > 0) begin
         it.func = FUNC_LOOKUP;
         idx = $urandom_range(net_count - 1);
         a = {net_hi[idx], net_lo[idx]};
         width = net_v4[idx] ? 32 : 128;
         p = int'(net_plen[idx]);
         j = $urandom_range(9);
         if (j >= 2) begin
            if (j < 6 && p < width)
               j = $urandom_range(width - 1, p);
            else
               j = $urandom_range(width - 1);
            a[127 - j] = ~a[127 - j];
         end
         v4 = net_v4[idx];
         if ($urandom_range(9) == 0)
            v4 = ~v4;
         if (v4 && $urandom_range(3) == 0) begin
            it.v4 = 1'b0;
            it.hi = 64'd0;
            it.lo = {MAPPED_TAG, a[127:96]};
         end else if (v4) begin
            it.v4 = 1'b1;
            it.hi = {a[127:96], $urandom};
            if ($urandom_range(1) == 0)
               it.lo = 64'd0;
         end else begin
            it.v4 = 1'b0;
            it.hi = a[127:64];
            it.lo = a[63:0];
         end
      end else begin
         it.func = FUNC_LOOKUP;
         if ($urandom_range(3) == 0) begin
            // Near the mapped form, or exactly it.
            it.hi = 64'd0;
            it.lo = {($urandom_range(1) == 0) ? MAPPED_TAG : 32'h0000_fffe, $urandom};
            it.v4 = 1'b0;
         end
      end
      return it;
   endfunction

   task automatic drive_request(input net_request_type it);
      match_result_type want;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {it.plen, it.lo, it.hi};
      req_tuser = {it.v4, it.func};
      do
         @(posedge clock);
      while (!req_tready);
      want = cidr_predict(it);
      if (it.typed) begin
         want.matched = it.exp_matched;
         want.status = it.exp_status;
      end
      pending_results = {pending_results, want};
      @(negedge clock);
   endtask

   always @(negedge clock)
      rsp_tready = ($urandom_range(99) >= stall_pct);

   // Scoreboard and watchdog.
   always @(posedge clock) begin : result_check
      match_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result item: rsp_tdata %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[0] !== want.matched) begin
                  $error("matched: expected %0d, actual %0d", want.matched, rsp_tdata[0]);
                  mismatch_count++;
               end
               if (rsp_tdata[2:1] !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tdata[2:1]);
                  mismatch_count++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin : stimulus
      net_request_type it;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty table, oversized prefixes, then a handful of networks and probes around them.
      add_row(FUNC_LOOKUP, '1, '1, 1'b1, 8'd0, 1'b1, 1'b0, STATUS_OK);
      add_row(FUNC_LOOKUP, '1, '1, 1'b0, 8'd255, 1'b1, 1'b0, STATUS_OK);
      add_row(FUNC_ADD, 64'h0a00_0000_0000_0000, 64'd0, 1'b1, 8'd33, 1'b1, 1'b0, STATUS_PREFIX);
      add_row(FUNC_ADD, 64'h2001_0db8_0000_0000, 64'd0, 1'b0, 8'd129, 1'b1, 1'b0,
              STATUS_PREFIX);
      add_row(FUNC_ADD, '1, '1, 1'b0, 8'd255, 1'b1, 1'b0, STATUS_PREFIX);
      add_row(FUNC_ADD, '1, '1, 1'b1, 8'd255, 1'b1, 1'b0, STATUS_PREFIX);
      add_row(FUNC_ADD, 64'd0, 64'h0000_ffff_0a00_0000, 1'b0, 8'd33, 1'b1, 1'b0,
              STATUS_PREFIX);
      add_row(FUNC_ADD, 64'h0a00_0000_dead_beef, 64'h1234_5678_9abc_def0, 1'b1, 8'd8,
              1'b1, 1'b0, STATUS_OK);
      add_row(FUNC_LOOKUP, 64'h0a01_0203_5555_aaaa, 64'hffff_0000_ffff_0000, 1'b1, 8'd7,
              1'b0, 1'b0, STATUS_OK);
      add_row(FUNC_LOOKUP, 64'h0b00_0000_0000_0000, 64'd0, 1'b1, 8'd0, 1'b0, 1'b0, STATUS_OK);
      add_row(FUNC_ADD, 64'h2001_0db8_0000_0000, 64'd0, 1'b0, 8'd32, 1'b1, 1'b0, STATUS_OK);
      add_row(FUNC_LOOKUP, 64'h2001_0db8_ffff_0001, '1, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_OK);
      add_row(FUNC_LOOKUP, 64'd0, 64'h0000_ffff_0a09_0909, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_OK);
      add_row(FUNC_ADD, 64'd0, 64'h0000_ffff_c0a8_0100, 1'b0, 8'd24, 1'b1, 1'b0, STATUS_OK);
      add_row(FUNC_LOOKUP, 64'hc0a8_014d_0000_0000, 64'd0, 1'b1, 8'd0, 1'b0, 1'b0, STATUS_OK);
      add_row(FUNC_LOOKUP, 64'd0, 64'h0000_fffe_c0a8_0101, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_OK);
      add_row(FUNC_ADD, '1, '1, 1'b0, 8'd128, 1'b1, 1'b0, STATUS_OK);
      add_row(FUNC_LOOKUP, '1, '1, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_OK);
      add_row(FUNC_LOOKUP, '1, 64'hffff_ffff_ffff_fffe, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_OK);
      add_row(FUNC_ADD, 64'hffff_ffff_0000_0000, 64'd0, 1'b1, 8'd32, 1'b1, 1'b0, STATUS_OK);
      add_row(FUNC_LOOKUP, 64'hffff_fffe_0000_0000, 64'd0, 1'b1, 8'd0, 1'b0, 1'b0, STATUS_OK);
      add_row(FUNC_LOOKUP, 64'hffff_ffff_ffff_ffff, '1, 1'b1, 8'd255, 1'b0, 1'b0, STATUS_OK);
      add_row(FUNC_LOOKUP, 64'd0, 64'd0, 1'b1, 8'd0, 1'b0, 1'b0, STATUS_OK);

      foreach (directed_rows[k])
         drive_request(directed_rows[k]);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 86;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 86;
            end
            default: begin
               idle_pct = 15;
               stall_pct = 15;
            end
         endcase
         if (phase == 3) begin
            // The last free slot takes an IPv6 network of length zero, which covers all IPv6.
            it = random_request(1'b1);
            it.func = FUNC_ADD;
            it.hi = 64'd0;
            it.lo = 64'd0;
            it.v4 = 1'b0;
            it.plen = 8'd0;
            drive_request(it);
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            drive_request(random_request(phase == 3));
      end
      req_tvalid = 1'b0;

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("adds: %0d stored, %0d prefix too long, %0d table full; %0d networks held",
               n_add_ok, n_add_prefix, n_add_full, net_count);
      $display("lookups: %0d matched, %0d not matched; %0d mismatches",
               n_hit, n_miss, mismatch_count);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
